// ===== hdl/ree_pkg.sv =====
package ree_pkg;

    // field and datapath widths
    localparam int ELEM_W        = 16;
    localparam int ANG_W         = 16;
    localparam int THR_W         = 15;
    localparam int ORD_W         = 3;
    localparam int CORDIC_STAGES = 16;
    localparam int STG_W         = 5;

    // square root of a 62-bit radicand, one result bit per cell
    localparam int RAD_W     = 62;
    localparam int ROOT_W    = 31;
    localparam int REM_W     = 34;
    localparam int SQ_STAGES = 31;

    // cordic vector and angle accumulator
    localparam int XY_W = 36;
    localparam int Z_W  = 34;

    // rotation order codes
    localparam logic [ORD_W-1:0] ORD_XYZ = 3'd0;
    localparam logic [ORD_W-1:0] ORD_YXZ = 3'd1;
    localparam logic [ORD_W-1:0] ORD_ZXY = 3'd2;
    localparam logic [ORD_W-1:0] ORD_ZYX = 3'd3;
    localparam logic [ORD_W-1:0] ORD_YZX = 3'd4;
    localparam logic [ORD_W-1:0] ORD_XZY = 3'd5;

    // which lane feeds an output angle
    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_A,
        SRC_B,
        SRC_C
    } t_src;

    typedef struct packed {
        t_src sx;
        t_src sy;
        t_src sz;
        logic bad;
    } t_ctl;

    // data carried alongside the square root cells
    typedef struct packed {
        logic signed [ELEM_W-1:0] s;
        logic signed [ELEM_W:0]   by;
        logic signed [ELEM_W:0]   bx;
        logic signed [ELEM_W:0]   cy;
        logic signed [ELEM_W:0]   cx;
        t_ctl                     ctl;
    } t_side;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } t_vec;

    // atan(2^-i), one full turn is 2^32
    function automatic logic [31:0] atan_lut(input logic [STG_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/rotation_matrix_to_euler_unit.sv =====
// rotation matrix to euler angles: takes a 3x3 rotation matrix (q2.14 elements) and an
// axis order and gives the three angles in binary angle units (pi = 32768), one matrix
// per clock when the output keeps up. the middle angle is asin of the pivot element,
// built as atan2(s, sqrt(1 - s^2)); the other two are atan2 of element pairs, one of them zero
// in gimbal lock. every item goes through input register, order decode, pivot square,
// 31 square-root cells (one root bit each), a quadrant stage and 16 cordic cells in three
// parallel lanes, then the output register. a small skid stage behind the output lets the
// pipeline keep moving one word while the sink stalls. the gimbal threshold register sits
// at address 0 of the apb port and resets to 16384 (one); orders 6 and 7 give zero angles
// with the flag set in tuser
module rotation_matrix_to_euler_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [143:0] i_s_tdata,  // r1c1, r1c2, r1c3, r2c1, r2c2, r2c3, r3c1, r3c2, r3c3
    input  logic [2:0]   i_s_tuser,  // rotation_order
    // output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [47:0]  o_m_tdata,  // angle_x, angle_y, angle_z
    output logic [0:0]   o_m_tuser,  // bad_order
    // configuration
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);

    localparam int EW  = ree_pkg::ELEM_W;
    localparam int NS  = ree_pkg::CORDIC_STAGES;
    localparam int QSH = 32 - ree_pkg::ELEM_W;              // element to q30
    localparam int ONE = 1 << (ree_pkg::ELEM_W - 2);
    localparam int OUT_W = 3 * ree_pkg::ANG_W;

    typedef logic signed [EW-1:0] t_elem;
    typedef logic signed [EW:0]   t_wide;

    // whole pipeline moves unless the skid stage is holding a word
    logic en;

    // ---------------------------------------------------------------- config
    logic [ree_pkg::THR_W-1:0] r_thr;
    logic                      cfg_wr;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_prdata = (i_paddr[2] == 1'b0) ? 32'(r_thr) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ree_pkg::THR_W'(16384);
        end else if (cfg_wr && (i_paddr[2] == 1'b0)) begin
            r_thr <= i_pwdata[ree_pkg::THR_W-1:0];
        end
    end

    // ---------------------------------------------------------------- input register
    logic         r_a_vld;
    logic [143:0] r_a_data;
    logic [2:0]   r_a_ord;

    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_s_tvalid;
        end
        if (en) begin
            r_a_data <= i_s_tdata;
            r_a_ord  <= i_s_tuser;
        end
    end

    // ---------------------------------------------------------------- order decode
    function automatic t_wide wext(input t_elem e);
        return t_wide'(e);
    endfunction

    function automatic t_wide wneg(input t_elem e);
        return -t_wide'(e);
    endfunction

    function automatic t_elem clamp1(input t_elem e);
        t_elem r;
        if (e > t_elem'(ONE)) begin
            r = t_elem'(ONE);
        end else if (e < -t_elem'(ONE)) begin
            r = -t_elem'(ONE);
        end else begin
            r = e;
        end
        return r;
    endfunction

    t_elem          m11, m12, m13, m21, m22, m23, m31, m32, m33;
    ree_pkg::t_side n_b;
    ree_pkg::t_side r_b;
    logic           r_b_vld;
    t_wide          pivot;
    logic [EW:0]    piv_abs;
    logic           locked;

    always_comb begin
        m11 = t_elem'(r_a_data[0*EW +: EW]);
        m12 = t_elem'(r_a_data[1*EW +: EW]);
        m13 = t_elem'(r_a_data[2*EW +: EW]);
        m21 = t_elem'(r_a_data[3*EW +: EW]);
        m22 = t_elem'(r_a_data[4*EW +: EW]);
        m23 = t_elem'(r_a_data[5*EW +: EW]);
        m31 = t_elem'(r_a_data[6*EW +: EW]);
        m32 = t_elem'(r_a_data[7*EW +: EW]);
        m33 = t_elem'(r_a_data[8*EW +: EW]);

        // pivot element per order, its raw magnitude decides gimbal lock
        unique case (r_a_ord)
            ree_pkg::ORD_XYZ: pivot = wext(m13);
            ree_pkg::ORD_YXZ: pivot = wext(m23);
            ree_pkg::ORD_ZXY: pivot = wext(m32);
            ree_pkg::ORD_ZYX: pivot = wext(m31);
            ree_pkg::ORD_YZX: pivot = wext(m21);
            ree_pkg::ORD_XZY: pivot = wext(m12);
            default:          pivot = '0;
        endcase
        piv_abs = (pivot < 0) ? (EW+1)'(-pivot) : (EW+1)'(pivot);
        locked  = piv_abs >= (EW+1)'(r_thr);

        n_b        = '0;
        n_b.ctl.sx = ree_pkg::SRC_ZERO;
        n_b.ctl.sy = ree_pkg::SRC_ZERO;
        n_b.ctl.sz = ree_pkg::SRC_ZERO;
        // lane a: asin, lanes b and c: atan2(y, x)
        unique case (r_a_ord)
            ree_pkg::ORD_XYZ: begin
                n_b.s      = clamp1(m13);
                n_b.ctl.sy = ree_pkg::SRC_A;
                n_b.ctl.sx = ree_pkg::SRC_B;
                if (!locked) begin
                    n_b.by = wneg(m23); n_b.bx = wext(m33);
                    n_b.cy = wneg(m12); n_b.cx = wext(m11);
                    n_b.ctl.sz = ree_pkg::SRC_C;
                end else begin
                    n_b.by = wext(m32); n_b.bx = wext(m22);
                end
            end
            ree_pkg::ORD_YXZ: begin
                n_b.s      = -clamp1(m23);
                n_b.ctl.sx = ree_pkg::SRC_A;
                n_b.ctl.sy = ree_pkg::SRC_B;
                if (!locked) begin
                    n_b.by = wext(m13); n_b.bx = wext(m33);
                    n_b.cy = wext(m21); n_b.cx = wext(m22);
                    n_b.ctl.sz = ree_pkg::SRC_C;
                end else begin
                    n_b.by = wneg(m31); n_b.bx = wext(m11);
                end
            end
            ree_pkg::ORD_ZXY: begin
                n_b.s      = clamp1(m32);
                n_b.ctl.sx = ree_pkg::SRC_A;
                n_b.ctl.sz = ree_pkg::SRC_C;
                if (!locked) begin
                    n_b.by = wneg(m31); n_b.bx = wext(m33);
                    n_b.cy = wneg(m12); n_b.cx = wext(m22);
                    n_b.ctl.sy = ree_pkg::SRC_B;
                end else begin
                    n_b.cy = wext(m21); n_b.cx = wext(m11);
                end
            end
            ree_pkg::ORD_ZYX: begin
                n_b.s      = -clamp1(m31);
                n_b.ctl.sy = ree_pkg::SRC_A;
                n_b.ctl.sz = ree_pkg::SRC_C;
                if (!locked) begin
                    n_b.by = wext(m32); n_b.bx = wext(m33);
                    n_b.cy = wext(m21); n_b.cx = wext(m11);
                    n_b.ctl.sx = ree_pkg::SRC_B;
                end else begin
                    n_b.cy = wneg(m12); n_b.cx = wext(m22);
                end
            end
            ree_pkg::ORD_YZX: begin
                n_b.s      = clamp1(m21);
                n_b.ctl.sz = ree_pkg::SRC_A;
                n_b.ctl.sy = ree_pkg::SRC_C;
                if (!locked) begin
                    n_b.by = wneg(m23); n_b.bx = wext(m22);
                    n_b.cy = wneg(m31); n_b.cx = wext(m11);
                    n_b.ctl.sx = ree_pkg::SRC_B;
                end else begin
                    n_b.cy = wext(m13); n_b.cx = wext(m33);
                end
            end
            ree_pkg::ORD_XZY: begin
                n_b.s      = -clamp1(m12);
                n_b.ctl.sz = ree_pkg::SRC_A;
                n_b.ctl.sx = ree_pkg::SRC_B;
                if (!locked) begin
                    n_b.by = wext(m32); n_b.bx = wext(m22);
                    n_b.cy = wext(m13); n_b.cx = wext(m11);
                    n_b.ctl.sy = ree_pkg::SRC_C;
                end else begin
                    n_b.by = wneg(m23); n_b.bx = wext(m33);
                end
            end
            default: begin
                n_b.ctl.bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
        if (en) begin
            r_b <= n_b;
        end
    end

    // ---------------------------------------------------------------- pivot square
    // radicand is (1 - s^2) in q28, scaled by 2^32 to match the q30 root
    logic signed [2*EW-1:0]    sq;
    logic [EW*2-4:0]           rem1;
    logic                      r_c_vld;
    logic [ree_pkg::RAD_W-1:0] r_c_rad;
    ree_pkg::t_side            r_c_side;

    always_comb begin
        sq   = r_b.s * r_b.s;
        rem1 = (EW*2-3)'(1 << (2*EW-4)) - sq[EW*2-4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
        if (en) begin
            r_c_rad  <= ree_pkg::RAD_W'({rem1, 32'd0});
            r_c_side <= r_b;
        end
    end

    // ---------------------------------------------------------------- square root cells
    logic                       sq_vld  [ree_pkg::SQ_STAGES+1];
    logic [ree_pkg::REM_W-1:0]  sq_rem  [ree_pkg::SQ_STAGES+1];
    logic [ree_pkg::ROOT_W-1:0] sq_root [ree_pkg::SQ_STAGES+1];
    logic [ree_pkg::RAD_W-1:0]  sq_rad  [ree_pkg::SQ_STAGES+1];
    ree_pkg::t_side             sq_side [ree_pkg::SQ_STAGES+1];

    assign sq_vld[0]  = r_c_vld;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = r_c_rad;
    assign sq_side[0] = r_c_side;

    for (genvar k = 0; k < ree_pkg::SQ_STAGES; k++) begin : g_sqrt
        ree_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_vld  (sq_vld[k]),
            .i_rem  (sq_rem[k]),
            .i_root (sq_root[k]),
            .i_rad  (sq_rad[k]),
            .i_side (sq_side[k]),
            .o_vld  (sq_vld[k+1]),
            .o_rem  (sq_rem[k+1]),
            .o_root (sq_root[k+1]),
            .o_rad  (sq_rad[k+1]),
            .o_side (sq_side[k+1])
        );
    end

    // ---------------------------------------------------------------- quadrant stage
    // left half plane is turned by a quarter turn so cordic sees x >= 0
    function automatic ree_pkg::t_vec prerot(input logic signed [ree_pkg::XY_W-1:0] y,
                                             input logic signed [ree_pkg::XY_W-1:0] x);
        ree_pkg::t_vec v;
        v.zero = (x == 0) && (y == 0);
        if (x < 0) begin
            if (y >= 0) begin
                v.x = y;
                v.y = -x;
                v.z = ree_pkg::Z_W'(32'h4000_0000);
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -ree_pkg::Z_W'(32'h4000_0000);
            end
        end else begin
            v.x = x;
            v.y = y;
            v.z = '0;
        end
        return v;
    endfunction

    function automatic logic signed [ree_pkg::XY_W-1:0] q30(input t_wide e);
        return ree_pkg::XY_W'(e) <<< QSH;
    endfunction

    ree_pkg::t_side side_end;
    ree_pkg::t_vec  r_d_a, r_d_b, r_d_c;

    logic                 cd_vld [NS+1];
    ree_pkg::t_ctl        cd_ctl [NS+1];
    logic                 r_cd_vld [NS+1];
    ree_pkg::t_ctl        r_cd_ctl [NS+1];

    assign side_end = sq_side[ree_pkg::SQ_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_vld[0] <= 1'b0;
        end else if (en) begin
            r_cd_vld[0] <= sq_vld[ree_pkg::SQ_STAGES];
        end
        if (en) begin
            r_d_a <= prerot(q30(wext(side_end.s)),
                            ree_pkg::XY_W'(sq_root[ree_pkg::SQ_STAGES]));
            r_d_b <= prerot(q30(side_end.by), q30(side_end.bx));
            r_d_c <= prerot(q30(side_end.cy), q30(side_end.cx));
            r_cd_ctl[0] <= side_end.ctl;
        end
    end

    // ---------------------------------------------------------------- cordic lanes
    ree_pkg::t_vec va [NS+1];
    ree_pkg::t_vec vb [NS+1];
    ree_pkg::t_vec vc [NS+1];

    assign va[0] = r_d_a;
    assign vb[0] = r_d_b;
    assign vc[0] = r_d_c;

    for (genvar k = 0; k < NS; k++) begin : g_cordic
        ree_cordic_cell u_a (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_stage(ree_pkg::STG_W'(k)),
            .i_vec  (va[k]),
            .o_vec  (va[k+1])
        );
        ree_cordic_cell u_b (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_stage(ree_pkg::STG_W'(k)),
            .i_vec  (vb[k]),
            .o_vec  (vb[k+1])
        );
        ree_cordic_cell u_c (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_stage(ree_pkg::STG_W'(k)),
            .i_vec  (vc[k]),
            .o_vec  (vc[k+1])
        );

        // order and flag travel beside the lanes
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cd_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_cd_vld[k+1] <= r_cd_vld[k];
            end
            if (en) begin
                r_cd_ctl[k+1] <= r_cd_ctl[k];
            end
        end
    end

    for (genvar k = 0; k <= NS; k++) begin : g_line
        assign cd_vld[k] = r_cd_vld[k];
        assign cd_ctl[k] = r_cd_ctl[k];
    end

    // ---------------------------------------------------------------- rounding and routing
    function automatic logic [ree_pkg::ANG_W-1:0] to_ang(input ree_pkg::t_vec v);
        logic [31:0] t;
        t = (v.zero ? 32'd0 : v.z[31:0]) + 32'(1 << (31 - ree_pkg::ANG_W));
        return t[31 -: ree_pkg::ANG_W];
    endfunction

    function automatic logic [ree_pkg::ANG_W-1:0] pick(input ree_pkg::t_src s,
                                                       input logic [ree_pkg::ANG_W-1:0] a,
                                                       input logic [ree_pkg::ANG_W-1:0] b,
                                                       input logic [ree_pkg::ANG_W-1:0] c);
        logic [ree_pkg::ANG_W-1:0] r;
        unique case (s)
            ree_pkg::SRC_A: r = a;
            ree_pkg::SRC_B: r = b;
            ree_pkg::SRC_C: r = c;
            default:        r = '0;
        endcase
        return r;
    endfunction

    logic [ree_pkg::ANG_W-1:0] ang_a, ang_b, ang_c;
    logic [OUT_W-1:0]          res_data;
    logic                      res_bad;
    logic                      res_vld;
    ree_pkg::t_ctl             ctl_end;

    always_comb begin
        ctl_end  = cd_ctl[NS];
        ang_a    = to_ang(va[NS]);
        ang_b    = to_ang(vb[NS]);
        ang_c    = to_ang(vc[NS]);
        res_vld  = cd_vld[NS];
        res_bad  = ctl_end.bad;
        res_data = {pick(ctl_end.sz, ang_a, ang_b, ang_c),
                    pick(ctl_end.sy, ang_a, ang_b, ang_c),
                    pick(ctl_end.sx, ang_a, ang_b, ang_c)};
    end

    // ---------------------------------------------------------------- output and skid
    logic             r_ov, r_sv;
    logic [OUT_W-1:0] r_od, r_sd;
    logic             r_ob, r_sb;
    logic             take;

    assign en   = !r_sv;
    assign take = r_ov && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (take) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end
        end else if (res_vld) begin
            if (!r_ov || take) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (take) begin
            r_ov <= 1'b0;
        end

        if (r_sv) begin
            if (take) begin
                r_od <= r_sd;
                r_ob <= r_sb;
            end
        end else if (res_vld) begin
            if (!r_ov || take) begin
                r_od <= res_data;
                r_ob <= res_bad;
            end else begin
                r_sd <= res_data;
                r_sb <= res_bad;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tuser  = r_ob;

endmodule

// ===== hdl/ree_sqrt_cell.sv =====
module ree_sqrt_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [ree_pkg::REM_W-1:0]     i_rem,
    input  logic [ree_pkg::ROOT_W-1:0]    i_root,
    input  logic [ree_pkg::RAD_W-1:0]     i_rad,
    input  ree_pkg::t_side                i_side,
    output logic                          o_vld,
    output logic [ree_pkg::REM_W-1:0]     o_rem,
    output logic [ree_pkg::ROOT_W-1:0]    o_root,
    output logic [ree_pkg::RAD_W-1:0]     o_rad,
    output ree_pkg::t_side                o_side
);

    logic [ree_pkg::REM_W+1:0]  rsh;
    logic [ree_pkg::REM_W+1:0]  trial;
    logic [ree_pkg::REM_W-1:0]  n_rem;
    logic [ree_pkg::ROOT_W-1:0] n_root;
    logic                       r_vld;
    logic [ree_pkg::REM_W-1:0]  r_rem;
    logic [ree_pkg::ROOT_W-1:0] r_root;
    logic [ree_pkg::RAD_W-1:0]  r_rad;
    ree_pkg::t_side             r_side;

    // one restoring step: bring down two radicand bits, try root*4+1
    always_comb begin
        rsh   = {i_rem, i_rad[ree_pkg::RAD_W-1 -: 2]};
        trial = (ree_pkg::REM_W+2)'({i_root, 2'b01});
        if (rsh >= trial) begin
            n_rem  = ree_pkg::REM_W'(rsh - trial);
            n_root = {i_root[ree_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = rsh[ree_pkg::REM_W-1:0];
            n_root = {i_root[ree_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= {i_rad[ree_pkg::RAD_W-3:0], 2'b00};
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
    assign o_side = r_side;

endmodule

// ===== hdl/ree_cordic_cell.sv =====
module ree_cordic_cell (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ree_pkg::STG_W-1:0]    i_stage,
    input  ree_pkg::t_vec                i_vec,
    output ree_pkg::t_vec                o_vec
);

    logic signed [ree_pkg::XY_W-1:0] xs;
    logic signed [ree_pkg::XY_W-1:0] ys;
    logic signed [ree_pkg::Z_W-1:0]  dz;
    ree_pkg::t_vec                   n_vec;
    ree_pkg::t_vec                   r_vec;

    // vectoring micro-rotation, drives y towards zero
    always_comb begin
        xs    = i_vec.x >>> i_stage;
        ys    = i_vec.y >>> i_stage;
        dz    = signed'(ree_pkg::Z_W'(ree_pkg::atan_lut(i_stage)));
        n_vec = i_vec;
        if (i_vec.y > 0) begin
            n_vec.x = i_vec.x + ys;
            n_vec.y = i_vec.y - xs;
            n_vec.z = i_vec.z + dz;
        end else begin
            n_vec.x = i_vec.x - ys;
            n_vec.y = i_vec.y + xs;
            n_vec.z = i_vec.z - dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule
